@@ hw/rtl/irtt_pkg.sv @@
// package: transaction types, state encoding and digit character mapping
package irtt_pkg;

    localparam int unsigned CHUNK_BITS = 8;
    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] DIGIT_MAX = 6'd35;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_QUERY = 8'h3f;

    typedef struct packed {
        logic        kind;
        logic [63:0] value;
    } t_in;

    typedef struct packed {
        logic [7:0] character;
        logic       minus_before;
        logic       last;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_SEND
    } t_state;

    function automatic logic [7:0] digit_char(input logic [5:0] d);
        logic [7:0] c;
        if (d < 6'd10) begin
            c = CHAR_ZERO + {2'b00, d};
        end else if (d <= DIGIT_MAX) begin
            c = CHAR_LOWER_A + {2'b00, d} - 8'd10;
        end else begin
            c = CHAR_QUERY;
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/integer_radix_to_text.sv @@
// top level: integer to ascii text in a configurable radix
// the radix divider takes the value eight bits per step for each digit,
// then each character goes through the digit memory read port and output register
// one number at a time: a new number is taken only in idle, after the last character
// reset: synchronous, radix back to 10, control idle; digit memory is not cleared
module integer_radix_to_text #(
    parameter int unsigned VALUE_WIDTH = 64,
    parameter int unsigned DIGIT_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [5:0]       i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  irtt_pkg::t_in    i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output irtt_pkg::t_out   o_out
);
    import irtt_pkg::*;

    localparam int unsigned STEPS = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int unsigned PAD_W = STEPS * CHUNK_BITS;
    localparam int unsigned SW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int unsigned AW = (DIGIT_DEPTH > 1) ? $clog2(DIGIT_DEPTH) : 1;
    localparam int unsigned CW = $clog2(DIGIT_DEPTH + 1);

    t_state               r_state, n_state;
    logic [5:0]           r_radix;
    logic [5:0]           r_rdx;
    logic                 r_neg;
    logic                 r_first;
    logic [PAD_W-1:0]     r_quot;
    logic [5:0]           r_rem;
    logic [SW-1:0]        r_step;
    logic [CW-1:0]        r_cnt;
    logic [AW-1:0]        r_rd;
    logic [5:0]           r_mem_q;
    logic [5:0]           mem [DIGIT_DEPTH];

    logic                 in_acc;
    logic                 out_acc;
    logic                 step_done;
    logic                 div_end;
    logic                 mem_we;
    logic [VALUE_WIDTH-1:0] v_in;
    logic [VALUE_WIDTH-1:0] v_mag;
    logic                 v_neg;
    logic [5:0]           eff_rdx;
    logic [5:0]           rem_new;
    logic [CHUNK_BITS-1:0] q_bits;
    logic [PAD_W-1:0]     quot_new;
    logic [CW-1:0]        cnt_inc;

    assign in_acc = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // input magnitude and sign
    assign v_in = i_in.value[VALUE_WIDTH-1:0];
    assign v_neg = i_in.kind && v_in[VALUE_WIDTH-1];
    assign v_mag = v_neg ? (~v_in + 1'b1) : v_in;

    always_comb begin
        if (r_radix < RADIX_MIN) begin
            eff_rdx = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            eff_rdx = RADIX_MAX;
        end else begin
            eff_rdx = r_radix;
        end
    end

    // eight restoring division steps per cycle on the narrow remainder
    always_comb begin
        logic [5:0]            rem;
        logic [6:0]            t;
        logic [CHUNK_BITS-1:0] chunk;
        rem = r_rem;
        chunk = r_quot[PAD_W-1 -: CHUNK_BITS];
        q_bits = '0;
        for (int k = 0; k < CHUNK_BITS; k++) begin
            t = {rem, chunk[CHUNK_BITS-1-k]};
            if (t >= {1'b0, r_rdx}) begin
                t = t - {1'b0, r_rdx};
                q_bits[CHUNK_BITS-1-k] = 1'b1;
            end
            rem = t[5:0];
        end
        rem_new = rem;
        quot_new = (r_quot << CHUNK_BITS) | PAD_W'(q_bits);
    end

    assign step_done = (r_step == SW'(STEPS - 1));
    assign cnt_inc = r_cnt + 1'b1;
    assign div_end = step_done && ((quot_new == '0) || (cnt_inc == CW'(DIGIT_DEPTH)));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_end) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (out_acc) begin
                    n_state = (r_rd == '0) ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        o_out_valid = 1'b0;
        mem_we = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
            end
            S_DIV: begin
                mem_we = step_done;
            end
            S_READ: begin
                o_in_stall = 1'b1;
            end
            S_SEND: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        o_out.character = digit_char(r_mem_q);
        o_out.minus_before = r_first && r_neg;
        o_out.last = (r_rd == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_radix <= RADIX_RESET;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_radix <= i_cfg_data;
            end
            if (in_acc) begin
                r_cnt <= '0;
            end else if (mem_we) begin
                r_cnt <= cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_quot <= PAD_W'(v_mag);
            r_rem <= '0;
            r_step <= '0;
            r_neg <= v_neg;
            r_rdx <= eff_rdx;
        end else if (r_state == S_DIV) begin
            r_quot <= quot_new;
            if (step_done) begin
                r_rem <= '0;
                r_step <= '0;
            end else begin
                r_rem <= rem_new;
                r_step <= r_step + 1'b1;
            end
        end
        if (r_state == S_DIV && div_end) begin
            r_rd <= r_cnt[AW-1:0];
            r_first <= 1'b1;
        end else if (out_acc) begin
            r_rd <= r_rd - 1'b1;
            r_first <= 1'b0;
        end
    end

    // digit memory, least significant digit at entry 0
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_cnt[AW-1:0]] <= rem_new;
        end
        r_mem_q <= mem[r_rd];
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DIGIT_DEPTH))
        else $error("digit count beyond memory depth");

    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_rdx))
        else $error("partial remainder not below radix");

    a_no_input_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a character is pending");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out.last) |=> (!o_out_valid && !o_in_stall))
        else $error("run continues after last character");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// testbench for integer_radix_to_text: directed and random numbers checked against a digit predictor
module testbench;
    import irtt_pkg::*;

    class text_scoreboard;
        logic [5:0] radix_reg;
        t_out pending_chars[$];
        int failures;
        string glyphs;

        function new();
            radix_reg = 6'd10;
            failures = 0;
            glyphs = "0123456789abcdefghijklmnopqrstuvwxyz";
        endfunction

        function void set_radix(logic [5:0] r);
            radix_reg = r;
        endfunction

        function logic [63:0] base_in_use();
            if (radix_reg < 6'd2) begin
                return 64'd2;
            end else if (radix_reg > 6'd36) begin
                return 64'd36;
            end
            return {58'd0, radix_reg};
        endfunction

        // spells one accepted number into the characters it should produce
        function void note_number(t_in item);
            logic [63:0] v;
            logic [63:0] base;
            logic [5:0] digits [64];
            int n;
            logic negative;
            t_out c;
            v = item.value;
            base = base_in_use();
            negative = 1'b0;
            n = 0;
            if (item.kind && v[63]) begin
                negative = 1'b1;
                v = ~v + 64'd1;
            end
            if (v == 64'd0) begin
                digits[0] = 6'd0;
                n = 1;
            end else begin
                while (v != 64'd0 && n < 64) begin
                    digits[n] = 6'(v % base);
                    v = v / base;
                    n++;
                end
            end
            for (int i = 0; i < n; i++) begin
                c.character = glyphs[digits[n - 1 - i]];
                c.minus_before = negative && (i == 0);
                c.last = (i == n - 1);
                pending_chars.push_back(c);
            end
        endfunction

        function void check_char(t_out got);
            t_out want;
            if (pending_chars.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected character %h minus %b last %b",
                             got.character, got.minus_before, got.last);
                end
                return;
            end
            want = pending_chars.pop_front();
            if (got.character !== want.character || got.minus_before !== want.minus_before
                    || got.last !== want.last) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch: expected char %h minus %b last %b, got char %h minus %b last %b",
                             want.character, want.minus_before, want.last,
                             got.character, got.minus_before, got.last);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [5:0] i_cfg_data = 6'd0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out;

    text_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    logic [5:0] radix_plan [12] = '{6'd10, 6'd2, 6'd36, 6'd0, 6'd1, 6'd37, 6'd63, 6'd16,
                                    6'd8, 6'd10, 6'd10, 6'd10};

    integer_radix_to_text DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out(o_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver back-pressure, with one long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_char(o_out);
        end
    end

    function automatic logic [63:0] pick_value(logic [63:0] base);
        logic [63:0] p;
        logic [63:0] full;
        int k;
        full = {$urandom, $urandom};
        p = 64'd1;
        case ($urandom_range(5))
            0: return full;
            1: return 64'($urandom_range(40));
            2: return full >> $urandom_range(63);
            3: begin
                case ($urandom_range(3))
                    0: p = 64'd0;
                    1: p = '1;
                    2: p = 64'h8000_0000_0000_0000;
                    default: p = 64'h7fff_ffff_ffff_ffff;
                endcase
                return p + 64'($urandom_range(2)) - 64'd1;
            end
            4: return 64'd0 - 64'($urandom_range(1, 1000));
            default: begin
                k = $urandom_range(1, 64);
                repeat (k) begin
                    if (p <= 64'hffff_ffff_ffff_ffff / base) begin
                        p = p * base;
                    end
                end
                return p + 64'($urandom_range(2)) - 64'd1;
            end
        endcase
    endfunction

    task automatic send_number(logic kind, logic [63:0] value);
        t_in item;
        item.kind = kind;
        item.value = value;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= item;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sb.note_number(item);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (sb.pending_chars.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_radix(logic [5:0] r);
        i_cfg_we <= 1'b1;
        i_cfg_data <= r;
        sb.set_radix(r);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int p = 0; p < 12; p++) begin
            if (p > 0) begin
                i_in_valid <= 1'b0;
                wait_drained();
                if (p == 9 || p == 10) begin
                    radix_plan[p] = 6'($urandom_range(63));
                end
                write_radix(radix_plan[p]);
            end
            if (p < 4) begin
                send_idle_pct = 6;
                recv_idle_pct = 57;
            end else if (p < 8) begin
                send_idle_pct = 57;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 9) begin
                hold_left = 600;
            end
            // reset radix, then binary and maximum radix edges
            if (p == 0) begin
                send_number(1'b0, 64'd0);
                send_number(1'b1, 64'd0);
                send_number(1'b0, '1);
                send_number(1'b1, '1);
                send_number(1'b1, 64'h8000_0000_0000_0000);
                send_number(1'b0, 64'h8000_0000_0000_0000);
                send_number(1'b1, 64'h7fff_ffff_ffff_ffff);
                send_number(1'b0, 64'd9);
                send_number(1'b0, 64'd10);
                send_number(1'b1, 64'd0 - 64'd100);
            end else if (p == 1) begin
                send_number(1'b0, '1);
                send_number(1'b1, 64'h8000_0000_0000_0000);
                send_number(1'b0, 64'd1);
                send_number(1'b1, 64'd0);
            end else if (p == 2) begin
                send_number(1'b0, 64'd35);
                send_number(1'b0, 64'd36);
                send_number(1'b0, '1);
                send_number(1'b1, '1);
            end
            repeat (25) begin
                send_number(1'($urandom_range(1)), pick_value(sb.base_in_use()));
            end
        end
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (700) @(negedge i_clk);
        if (sb.pending_chars.size() != 0) begin
            sb.failures++;
        end
        if (sb.failures == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule

@@ integer_radix_to_text.f @@
hw/rtl/irtt_pkg.sv
hw/rtl/integer_radix_to_text.sv
verif/testbench.sv
